>>> hw/rtl/lrt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lrt_pkg
// Shared constants and types for the luminance Reinhard tone mapper.
// ============================================================================
package lrt_pkg;

    // Default channel format: unsigned Q8.16.
    localparam int LRT_FRAC_BITS = 16;
    localparam int LRT_INT_BITS  = 8;

    // Luminance weights in Q0.16; they sum to exactly 65536.
    localparam int LRT_WEIGHT_BITS = 16;
    localparam logic [LRT_WEIGHT_BITS-1:0] LRT_WEIGHT_R = 16'd13933;
    localparam logic [LRT_WEIGHT_BITS-1:0] LRT_WEIGHT_G = 16'd46871;
    localparam logic [LRT_WEIGHT_BITS-1:0] LRT_WEIGHT_B = 16'd4732;

    // Per-stage control that travels alongside the pixel data.
    typedef struct packed {
        logic valid;
        logic last;
    } lrt_ctl_t;

endpackage

>>> hw/rtl/lrt_luma.sv
`timescale 1ns / 1ps
// ============================================================================
// lrt_luma
// Two-stage luminance path: weighted products, then rounded sum and the
// divisor 1 + Y in the channel format.
// ============================================================================
module lrt_luma #(
    parameter int FRAC_BITS = lrt_pkg::LRT_FRAC_BITS,
    parameter int INT_BITS  = lrt_pkg::LRT_INT_BITS,
    localparam int WordW    = INT_BITS + FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  lrt_pkg::lrt_ctl_t            in_ctl,
    input  logic [2:0][WordW-1:0]        in_chan,
    output lrt_pkg::lrt_ctl_t            out_ctl,
    output logic [2:0][WordW-1:0]        out_chan,
    output logic [WordW:0]               out_den
);
    import lrt_pkg::*;

    localparam int ProdW = WordW + LRT_WEIGHT_BITS;
    localparam int SumW  = ProdW + 2;
    localparam logic [SumW-1:0] RoundHalf = SumW'(1) << (LRT_WEIGHT_BITS - 1);
    localparam logic [WordW:0]  OneFix    = (WordW + 1)'(1) << FRAC_BITS;

    lrt_ctl_t              ctl_a_reg;
    logic [2:0][WordW-1:0] chan_a_reg;
    logic [ProdW-1:0]      prod_r_reg, prod_g_reg, prod_b_reg;
    logic [ProdW-1:0]      prod_r_next, prod_g_next, prod_b_next;

    lrt_ctl_t              ctl_b_reg;
    logic [2:0][WordW-1:0] chan_b_reg;
    logic [WordW:0]        den_reg, den_next;
    logic [SumW-1:0]       sum;
    logic [WordW-1:0]      lum;

    assign prod_r_next = ProdW'(in_chan[0]) * ProdW'(LRT_WEIGHT_R);
    assign prod_g_next = ProdW'(in_chan[1]) * ProdW'(LRT_WEIGHT_G);
    assign prod_b_next = ProdW'(in_chan[2]) * ProdW'(LRT_WEIGHT_B);

    // The weights sum to one, so the rounded luminance never exceeds the
    // largest channel value and fits the channel width.
    assign sum = SumW'(prod_r_reg) + SumW'(prod_g_reg) + SumW'(prod_b_reg) + RoundHalf;
    assign lum = sum[LRT_WEIGHT_BITS +: WordW];
    assign den_next = OneFix + {1'b0, lum};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end else if (en) begin
            ctl_a_reg <= in_ctl;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chan_a_reg <= in_chan;
            prod_r_reg <= prod_r_next;
            prod_g_reg <= prod_g_next;
            prod_b_reg <= prod_b_next;
            chan_b_reg <= chan_a_reg;
            den_reg    <= den_next;
        end
    end

    assign out_ctl  = ctl_b_reg;
    assign out_chan = chan_b_reg;
    assign out_den  = den_reg;

endmodule

>>> hw/rtl/lrt_divider.sv
`timescale 1ns / 1ps
// ============================================================================
// lrt_divider
// Pipelined restoring divider for three channels sharing one divisor:
// out = round(c * 2^FRAC_BITS / den), one quotient bit per stage.
// ============================================================================
module lrt_divider #(
    parameter int FRAC_BITS = lrt_pkg::LRT_FRAC_BITS,
    parameter int INT_BITS  = lrt_pkg::LRT_INT_BITS,
    localparam int WordW    = INT_BITS + FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  lrt_pkg::lrt_ctl_t            in_ctl,
    input  logic [2:0][WordW-1:0]        in_chan,
    input  logic [WordW:0]               in_den,
    output lrt_pkg::lrt_ctl_t            out_ctl,
    output logic [2:0][WordW-1:0]        out_chan
);
    import lrt_pkg::*;

    // Quotient bits needed: the channel width, since the result never exceeds the
    // channel value, plus one extra bit for rounding.
    localparam int NumSteps = WordW + 1;

    lrt_ctl_t              st_ctl [0:NumSteps];
    logic [WordW:0]        st_den [0:NumSteps];
    logic [2:0][WordW:0]   st_rem [0:NumSteps];
    logic [2:0][WordW:0]   st_num [0:NumSteps];
    logic [2:0][WordW:0]   st_quo [0:NumSteps];

    lrt_ctl_t              ctl_reg [0:NumSteps-1];
    logic [WordW:0]        den_reg [0:NumSteps-1];
    logic [2:0][WordW:0]   rem_reg [0:NumSteps-1];
    logic [2:0][WordW:0]   num_reg [0:NumSteps-1];
    logic [2:0][WordW:0]   quo_reg [0:NumSteps-1];

    lrt_ctl_t              out_ctl_reg;
    logic [2:0][WordW-1:0] res_reg, res_next;

    // The top FRAC_BITS numerator bits always give zero quotient bits, so
    // they go straight into the starting remainder.
    assign st_ctl[0] = in_ctl;
    assign st_den[0] = in_den;
    for (genvar ch = 0; ch < 3; ch++) begin : g_init
        assign st_rem[0][ch] = {(INT_BITS + 1)'(0), in_chan[ch][WordW-1:INT_BITS]};
        assign st_num[0][ch] = {in_chan[ch][INT_BITS-1:0], (FRAC_BITS + 1)'(0)};
        assign st_quo[0][ch] = '0;
    end

    for (genvar s = 0; s < NumSteps; s++) begin : g_step
        logic [2:0][WordW:0] rem_next;
        logic [2:0][WordW:0] num_next;
        logic [2:0][WordW:0] quo_next;

        always_comb begin
            logic [WordW+1:0] shifted;
            logic [WordW+1:0] diff;
            logic             fits;
            for (int ch = 0; ch < 3; ch++) begin
                shifted = {st_rem[s][ch], st_num[s][ch][WordW]};
                diff    = shifted - {1'b0, st_den[s]};
                fits    = shifted >= {1'b0, st_den[s]};
                rem_next[ch] = fits ? diff[WordW:0] : shifted[WordW:0];
                num_next[ch] = {st_num[s][ch][WordW-1:0], 1'b0};
                quo_next[ch] = {st_quo[s][ch][WordW-1:0], fits};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[s] <= '0;
            end else if (en) begin
                ctl_reg[s] <= st_ctl[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[s] <= st_den[s];
                rem_reg[s] <= rem_next;
                num_reg[s] <= num_next;
                quo_reg[s] <= quo_next;
            end
        end

        assign st_ctl[s+1] = ctl_reg[s];
        assign st_den[s+1] = den_reg[s];
        assign st_rem[s+1] = rem_reg[s];
        assign st_num[s+1] = num_reg[s];
        assign st_quo[s+1] = quo_reg[s];
    end

    // Round half up on the extra quotient bit, then clamp to all ones.
    always_comb begin
        logic [WordW+1:0] rounded;
        for (int ch = 0; ch < 3; ch++) begin
            rounded = {1'b0, st_quo[NumSteps][ch]} + (WordW + 2)'(1);
            if (rounded[WordW+1]) begin
                res_next[ch] = '1;
            end else begin
                res_next[ch] = rounded[WordW:1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_ctl_reg <= '0;
        end else if (en) begin
            out_ctl_reg <= st_ctl[NumSteps];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_ctl  = out_ctl_reg;
    assign out_chan = res_reg;

endmodule

>>> hw/rtl/luminance_reinhard_tonemap.sv
`timescale 1ns / 1ps
// ============================================================================
// luminance_reinhard_tonemap
// Reinhard tone mapping on luminance: every channel is scaled by 1 / (1 + Y).
// ============================================================================
// Accepts one linear RGB pixel per clock and returns one pixel per clock.
// Channels are unsigned fixed point with INT_BITS integer and FRAC_BITS
// fraction bits (Q8.16 by default). Y = 0.2126 R + 0.7152 G + 0.0722 B is
// formed with Q0.16 weights and rounded, and each output is
// round(c / (1 + Y)), clamped to all ones; black stays black and tlast is
// carried along. The restoring divider resolves one quotient bit per
// pipeline stage. Back-pressure on the result side stalls the whole
// pipeline; a one-entry skid buffer keeps s_tready a registered signal.
// ============================================================================
module luminance_reinhard_tonemap #(
    parameter int FRAC_BITS = lrt_pkg::LRT_FRAC_BITS,
    parameter int INT_BITS  = lrt_pkg::LRT_INT_BITS,
    localparam int WordW    = INT_BITS + FRAC_BITS,
    localparam int TdataW   = ((3 * WordW + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TdataW-1:0] s_tdata,   // red_in, green_in, blue_in, zero fill
    input  logic              s_tlast,   // last_pixel

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [TdataW-1:0] m_tdata,   // red_out, green_out, blue_out, zero fill
    output logic              m_tlast    // last_out
);
    import lrt_pkg::*;

    logic                  en;
    logic                  s_xfer;

    logic                  skid_full_reg, skid_full_next;
    logic [2:0][WordW-1:0] skid_chan_reg;
    logic                  skid_last_reg;

    logic [2:0][WordW-1:0] port_chan;
    lrt_ctl_t              in_ctl;
    logic [2:0][WordW-1:0] in_chan;

    lrt_ctl_t              luma_ctl;
    logic [2:0][WordW-1:0] luma_chan;
    logic [WordW:0]        luma_den;

    lrt_ctl_t              div_ctl;
    logic [2:0][WordW-1:0] div_chan;

    // The pipeline moves whenever the result register is empty or being read.
    assign en       = !div_ctl.valid || m_tready;
    assign s_tready = !skid_full_reg;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            port_chan[ch] = s_tdata[ch*WordW +: WordW];
        end
    end

    // A transfer that arrives during a stall is parked in the skid buffer and
    // enters the pipeline first once it moves again.
    always_comb begin
        if (skid_full_reg) begin
            in_chan      = skid_chan_reg;
            in_ctl.valid = 1'b1;
            in_ctl.last  = skid_last_reg;
        end else begin
            in_chan      = port_chan;
            in_ctl.valid = s_xfer;
            in_ctl.last  = s_tlast;
        end
    end

    always_comb begin
        skid_full_next = skid_full_reg;
        if (en) begin
            skid_full_next = 1'b0;
        end else if (s_xfer) begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_xfer) begin
            skid_chan_reg <= port_chan;
            skid_last_reg <= s_tlast;
        end
    end

    lrt_luma #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_luma (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   (in_ctl),
        .in_chan  (in_chan),
        .out_ctl  (luma_ctl),
        .out_chan (luma_chan),
        .out_den  (luma_den)
    );

    lrt_divider #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   (luma_ctl),
        .in_chan  (luma_chan),
        .in_den   (luma_den),
        .out_ctl  (div_ctl),
        .out_chan (div_chan)
    );

    assign m_tvalid = div_ctl.valid;
    assign m_tlast  = div_ctl.last;

    always_comb begin
        m_tdata = '0;
        for (int ch = 0; ch < 3; ch++) begin
            m_tdata[ch*WordW +: WordW] = div_chan[ch];
        end
    end

endmodule
